FILE: hw/rtl/ray_box_slab_test_macros.svh
// Assertion macros for the ray/box slab test block.
// Used by the top level only; no other dependencies.
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define RBST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define RBST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/rbst_pkg.sv
// Shared types and constants for the ray/box slab test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rbst_pkg;

	localparam int VALUE_W           = 32;
	localparam int DIFF_W            = VALUE_W + 1;
	localparam int PROD_W            = DIFF_W + VALUE_W;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int NUM_AXES          = 3;
	localparam int ADDR_W            = 5;
	localparam int IDX_W             = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} reg_idx_t;

	typedef logic [NUM_AXES-1:0][VALUE_W-1:0] vec3_t;

	// One ray as it travels down the chain; t_lo/t_hi get narrowed per axis.
	typedef struct packed {
		vec3_t                    origin;
		vec3_t                    inv_dir;
		logic [NUM_AXES-1:0]      dir_neg;
		logic signed [VALUE_W-1:0] t_lo;
		logic signed [VALUE_W-1:0] t_hi;
	} item_t;

endpackage

FILE: hw/rtl/rbst_apb_regs.sv
// APB register file holding the six box bounds.
// Depends on rbst_pkg.
`timescale 1ns / 1ps

module rbst_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbst_pkg::ADDR_W-1:0] paddr,
	input  logic [rbst_pkg::VALUE_W-1:0] pwdata,
	output logic [rbst_pkg::VALUE_W-1:0] prdata,
	output logic                       pready,
	output rbst_pkg::vec3_t            box_min,
	output rbst_pkg::vec3_t            box_max
);
	import rbst_pkg::*;

	vec3_t            box_min_q;
	vec3_t            box_max_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q <= '0;
			box_max_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BOX_MIN_X: box_min_q[0] <= pwdata;
				REG_BOX_MIN_Y: box_min_q[1] <= pwdata;
				REG_BOX_MIN_Z: box_min_q[2] <= pwdata;
				REG_BOX_MAX_X: box_max_q[0] <= pwdata;
				REG_BOX_MAX_Y: box_max_q[1] <= pwdata;
				REG_BOX_MAX_Z: box_max_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BOX_MIN_X: prdata = box_min_q[0];
			REG_BOX_MIN_Y: prdata = box_min_q[1];
			REG_BOX_MIN_Z: prdata = box_min_q[2];
			REG_BOX_MAX_X: prdata = box_max_q[0];
			REG_BOX_MAX_Y: prdata = box_max_q[1];
			REG_BOX_MAX_Z: prdata = box_max_q[2];
			default:       prdata = '0;
		endcase
	end

	assign box_min = box_min_q;
	assign box_max = box_max_q;

endmodule

FILE: hw/rtl/rbst_slab_cell.sv
// One axis of the slab test: four-stage cell that narrows the item's t interval.
// Depends on rbst_pkg; chained three times by the top level.
`timescale 1ns / 1ps

module rbst_slab_cell #(
	parameter int AXIS          = 0,
	parameter int FRACTION_BITS = rbst_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic signed [rbst_pkg::VALUE_W-1:0] bound_min,
	input  logic signed [rbst_pkg::VALUE_W-1:0] bound_max,
	input  logic                        up_valid,
	output logic                        up_stall,
	input  rbst_pkg::item_t             up_item,
	output logic                        dn_valid,
	input  logic                        dn_stall,
	output rbst_pkg::item_t             dn_item
);
	import rbst_pkg::*;

	// clamp a scaled product to the signed value range
	function automatic logic signed [VALUE_W-1:0] sat(input logic signed [PROD_W-1:0] v);
		logic all_one;
		logic any_one;
		all_one = &v[PROD_W-2:VALUE_W-1];
		any_one = |v[PROD_W-2:VALUE_W-1];
		if (!v[PROD_W-1] && any_one)
			sat = {1'b0, {(VALUE_W-1){1'b1}}};
		else if (v[PROD_W-1] && !all_one)
			sat = {1'b1, {(VALUE_W-1){1'b0}}};
		else
			sat = v[VALUE_W-1:0];
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;
	item_t item_s1, item_s2, item_s3, item_s4;

	logic signed [DIFF_W-1:0]  dnear_s1, dfar_s1;
	logic signed [VALUE_W-1:0] inv_s1;
	logic signed [PROD_W-1:0]  pnear_s2, pfar_s2;
	logic signed [VALUE_W-1:0] tnear_s3, tfar_s3;

	logic signed [VALUE_W-1:0] org, near_b, far_b;
	logic signed [DIFF_W-1:0]  dnear, dfar;
	logic signed [PROD_W-1:0]  pnear, pfar, snear, sfar;
	item_t                     narrowed;

	// a stage loads when it is empty or its successor loads
	assign en4      = !valid_s4 || !dn_stall;
	assign en3      = !valid_s3 || en4;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign up_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= up_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: distance from origin to the near and far bounds, kept exact
	always_comb begin
		org    = $signed(up_item.origin[AXIS]);
		near_b = up_item.dir_neg[AXIS] ? bound_max : bound_min;
		far_b  = up_item.dir_neg[AXIS] ? bound_min : bound_max;
		dnear  = {near_b[VALUE_W-1], near_b} - {org[VALUE_W-1], org};
		dfar   = {far_b[VALUE_W-1], far_b} - {org[VALUE_W-1], org};
	end

	// stage 2: exact signed products
	assign pnear = dnear_s1 * inv_s1;
	assign pfar  = dfar_s1 * inv_s1;

	// stage 3: arithmetic shift floors toward minus infinity
	assign snear = pnear_s2 >>> FRACTION_BITS;
	assign sfar  = pfar_s2 >>> FRACTION_BITS;

	// stage 4: narrow the interval
	always_comb begin
		narrowed = item_s3;
		if (tnear_s3 > item_s3.t_lo) narrowed.t_lo = tnear_s3;
		if (tfar_s3 < item_s3.t_hi)  narrowed.t_hi = tfar_s3;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1  <= up_item;
			dnear_s1 <= dnear;
			dfar_s1  <= dfar;
			inv_s1   <= $signed(up_item.inv_dir[AXIS]);
		end
		if (en2) begin
			item_s2  <= item_s1;
			pnear_s2 <= pnear;
			pfar_s2  <= pfar;
		end
		if (en3) begin
			item_s3  <= item_s2;
			tnear_s3 <= sat(snear);
			tfar_s3  <= sat(sfar);
		end
		if (en4) begin
			item_s4  <= narrowed;
		end
	end

	assign dn_valid = valid_s4;
	assign dn_item  = item_s4;

endmodule

FILE: hw/rtl/ray_box_slab_test.sv
// Ray against axis-aligned box, slab method. Usage summary:
//   Input channel: in_valid/in_stall with the ray origin, reciprocal direction,
//   per-axis negative-direction flags and the t interval [t_start, t_end].
//   Output channel: out_valid/out_stall with one hit bit per item, in order.
//   Box bounds are six signed Q16.16 registers on the APB port at 4*index
//   (min x, y, z, then max x, y, z); write them only while the block is idle.
//   Each item passes three axis cells in a row, four stages each: subtract,
//   multiply, scale/saturate, narrow.
//   Throughput: one item per cycle while out_stall is low; each cell is a short pipeline.
//   Reset clears the box registers to 0 and empties the pipeline.
//   When out_stall is held, items pack into empty stages behind the output;
//   in_stall rises only once all 12 stages hold an item.
// Depends on rbst_pkg, rbst_slab_cell, rbst_apb_regs and the macros header.
`timescale 1ns / 1ps
`include "ray_box_slab_test_macros.svh"

module ray_box_slab_test #(
	parameter int FRACTION_BITS = rbst_pkg::FRACTION_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rbst_pkg::ADDR_W-1:0] paddr,
	input  logic [rbst_pkg::VALUE_W-1:0] pwdata,
	output logic [rbst_pkg::VALUE_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [rbst_pkg::VALUE_W-1:0] origin_x,
	input  logic signed [rbst_pkg::VALUE_W-1:0] origin_y,
	input  logic signed [rbst_pkg::VALUE_W-1:0] origin_z,
	input  logic signed [rbst_pkg::VALUE_W-1:0] inv_dir_x,
	input  logic signed [rbst_pkg::VALUE_W-1:0] inv_dir_y,
	input  logic signed [rbst_pkg::VALUE_W-1:0] inv_dir_z,
	input  logic                        dir_neg_x,
	input  logic                        dir_neg_y,
	input  logic                        dir_neg_z,
	input  logic signed [rbst_pkg::VALUE_W-1:0] t_start,
	input  logic signed [rbst_pkg::VALUE_W-1:0] t_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit
);
	import rbst_pkg::*;

	vec3_t box_min, box_max;
	item_t link_item  [NUM_AXES+1];
	logic  link_valid [NUM_AXES+1];
	logic  link_stall [NUM_AXES+1];

	rbst_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.box_min (box_min),
		.box_max (box_max)
	);

	always_comb begin
		link_item[0].origin  = {origin_z, origin_y, origin_x};
		link_item[0].inv_dir = {inv_dir_z, inv_dir_y, inv_dir_x};
		link_item[0].dir_neg = {dir_neg_z, dir_neg_y, dir_neg_x};
		link_item[0].t_lo    = t_start;
		link_item[0].t_hi    = t_end;
	end

	assign link_valid[0] = in_valid;
	assign in_stall      = link_stall[0];

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
		rbst_slab_cell #(
			.AXIS          (g),
			.FRACTION_BITS (FRACTION_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bound_min ($signed(box_min[g])),
			.bound_max ($signed(box_max[g])),
			.up_valid  (link_valid[g]),
			.up_stall  (link_stall[g]),
			.up_item   (link_item[g]),
			.dn_valid  (link_valid[g+1]),
			.dn_stall  (link_stall[g+1]),
			.dn_item   (link_item[g+1])
		);
	end

	assign link_stall[NUM_AXES] = out_stall;
	assign out_valid = link_valid[NUM_AXES];
	assign hit       = (link_item[NUM_AXES].t_lo <= link_item[NUM_AXES].t_hi);

	// back-pressure reaches the input only through a blocked output
	`RBST_ASSERT_SAME(a_stall_source, clk, arst_n, in_stall, out_valid && out_stall, "input stalled while output is free")
	`RBST_ASSERT_NEXT(a_cfg_min_x, clk, arst_n, psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_BOX_MIN_X), box_min[0] == $past(pwdata), "box_min_x write lost")
	`RBST_ASSERT_NEXT(a_cfg_max_z, clk, arst_n, psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_BOX_MAX_Z), box_max[2] == $past(pwdata), "box_max_z write lost")

endmodule
